### rtl/assert_macros.svh
// assertion helpers, clocked on clk and disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DKS_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define DKS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define DKS_ASSERT(lbl, expr, msg)
`define DKS_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

### rtl/dks_pkg.sv
package dks_pkg;
  localparam int MOMENTUM_BITS_DEF = 24;
  localparam int OUT_W = 216;
  localparam int SUM_W = 35;
  localparam logic signed [SUM_W-1:0] COMP_LIMIT = 35'sd1073741823;
  localparam logic [23:0] HALF_TURN = 24'd8388608;
  localparam int CORDIC_STEPS = 20;
  localparam int STEP_W = $clog2(CORDIC_STEPS);

  function automatic logic [23:0] atan_turn(input logic [STEP_W-1:0] idx);
    logic [23:0] v;
    case (idx)
      5'd0: v = 24'd2097152;
      5'd1: v = 24'd1238021;
      5'd2: v = 24'd654136;
      5'd3: v = 24'd332049;
      5'd4: v = 24'd166669;
      5'd5: v = 24'd83416;
      5'd6: v = 24'd41718;
      5'd7: v = 24'd20860;
      5'd8: v = 24'd10430;
      5'd9: v = 24'd5215;
      5'd10: v = 24'd2608;
      5'd11: v = 24'd1304;
      5'd12: v = 24'd652;
      5'd13: v = 24'd326;
      5'd14: v = 24'd163;
      5'd15: v = 24'd81;
      5'd16: v = 24'd41;
      5'd17: v = 24'd20;
      5'd18: v = 24'd10;
      5'd19: v = 24'd5;
      default: v = 24'd0;
    endcase
    return v;
  endfunction
endpackage

### rtl/dijet_kinematics_summary_unit.sv
// Dijet kinematics summary. Jets of one event stream in leading first, one
// transaction each; a transaction without tlast is taken in one cycle. On the
// tlast transaction the block stops accepting until the summary is loaded,
// while one shared 32x32 multiplier squares the four-vector components and one
// square-root unit, two radicand bits a cycle, takes the five roots (pair
// mass, mass of jets two and three, three-jet mass, pair pT, missing HT);
// the pT balance divider and the missing-HT angle CORDIC run alongside.
// The summary waits in an output register, so the next event may start
// while it is still pending.
`include "assert_macros.svh"
module dijet_kinematics_summary_unit #(
  parameter int MOMENTUM_BITS = dks_pkg::MOMENTUM_BITS_DEF,
  localparam int IN_W = ((4 * MOMENTUM_BITS + 55 + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // mom_x, mom_y, mom_z, energy, rapidity, azimuth, trans_mom
  input  logic [IN_W-1:0]           s_tdata,
  // jet_present
  input  logic                      s_tuser,
  input  logic                      s_tlast,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // pair_mass, pair_pt, y_boost, y_star, delta_phi, pt_balance, mass_23,
  // mass_3j, missing_ht, missing_ht_phi
  output logic [dks_pkg::OUT_W-1:0] m_tdata,
  // pair_valid, triple_valid
  output logic [1:0]                m_tuser
);
  localparam int MB = MOMENTUM_BITS;
  localparam int SW = dks_pkg::SUM_W;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_SEL, S_MUL, S_ACC, S_ROOT, S_RWAIT, S_FINISH
  } state_t;
  typedef enum logic [2:0] {JOB_PAIR, JOB_23, JOB_3J, JOB_PT, JOB_MHT} job_t;
  typedef enum logic [1:0] {TERM_E, TERM_X, TERM_Y, TERM_Z} term_t;

  state_t state;
  job_t   job;
  term_t  term;

  logic [1:0] jets_seen;
  logic signed [MB-1:0] kept_x [3];
  logic signed [MB-1:0] kept_y [3];
  logic signed [MB-1:0] kept_z [3];
  logic [MB-1:0]        kept_e [3];
  logic signed [15:0]   kept_rap [2];
  logic [15:0]          kept_az [2];
  logic [22:0]          kept_pt [2];
  logic signed [31:0]   sum_nx;
  logic signed [31:0]   sum_ny;

  logic [31:0] comp_mag;
  logic [63:0] prod;
  logic signed [65:0] acc;

  logic signed [25:0] r_pair_mass;
  logic signed [25:0] r_mass_23;
  logic signed [25:0] r_mass_3j;
  logic [24:0] r_pair_pt;
  logic [31:0] r_mht;

  logic accept;
  logic signed [MB-1:0] in_x;
  logic signed [MB-1:0] in_y;
  logic signed [32:0] nx_next;
  logic signed [32:0] ny_next;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign in_x     = s_tdata[MB-1:0];
  assign in_y     = s_tdata[2*MB-1:MB];
  assign nx_next  = 33'(sum_nx) - 33'(in_x);
  assign ny_next  = 33'(sum_ny) - 33'(in_y);

  // component of the current term
  logic signed [SW-1:0] ext [3];
  logic [2:0] sel;
  logic signed [SW-1:0] csum;
  logic signed [SW-1:0] comp;
  logic [SW-1:0] comp_abs;
  logic last_term;
  logic neg_term;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      case (term)
        TERM_E: ext[k] = SW'($signed({1'b0, kept_e[k]}));
        TERM_X: ext[k] = SW'(kept_x[k]);
        TERM_Y: ext[k] = SW'(kept_y[k]);
        default: ext[k] = SW'(kept_z[k]);
      endcase
    end
    unique case (job)
      JOB_PAIR, JOB_PT: sel = 3'b011;
      JOB_23: sel = 3'b110;
      JOB_3J: sel = 3'b111;
      default: sel = 3'b000;
    endcase
    csum = (sel[0] ? ext[0] : '0) + (sel[1] ? ext[1] : '0) + (sel[2] ? ext[2] : '0);
    if (job == JOB_MHT) begin
      comp = (term == TERM_X) ? SW'(sum_nx) : SW'(sum_ny);
    end else if (csum > dks_pkg::COMP_LIMIT) begin
      comp = dks_pkg::COMP_LIMIT;
    end else if (csum < -dks_pkg::COMP_LIMIT) begin
      comp = -dks_pkg::COMP_LIMIT;
    end else begin
      comp = csum;
    end
    comp_abs  = comp[SW-1] ? SW'(-comp) : comp;
    neg_term  = (job == JOB_PAIR || job == JOB_23 || job == JOB_3J) && term != TERM_E;
    last_term = (job == JOB_PAIR || job == JOB_23 || job == JOB_3J) ?
                (term == TERM_Z) : (term == TERM_Y);
  end

  // shared square root
  logic        sq_start;
  logic        sq_busy;
  logic [31:0] sq_root;
  logic [63:0] radicand;

  assign sq_start = (state == S_ROOT);
  assign radicand = acc[65] ? 64'(-acc) : acc[63:0];

  dks_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (radicand),
    .busy     (sq_busy),
    .root     (sq_root)
  );

  logic signed [25:0] mass_val;
  always_comb begin
    if (!acc[65]) begin
      mass_val = (sq_root > 32'd33554431) ? 26'sh1FFFFFF : 26'(sq_root);
    end else begin
      mass_val = (sq_root > 32'd33554432) ? 26'sh2000000 : 26'(~sq_root + 32'd1);
    end
  end

  // balance divider and angle unit
  logic aux_start;
  logic div_busy;
  logic cor_busy;
  logic [39:0] quot;
  logic [15:0] mht_phi;
  logic [23:0] pt_s;
  logic signed [23:0] pt_diff;
  logic [22:0] pt_mag;

  assign aux_start = (state == S_START);
  assign pt_s      = 24'(kept_pt[0]) + 24'(kept_pt[1]);
  assign pt_diff   = $signed({1'b0, kept_pt[0]}) - $signed({1'b0, kept_pt[1]});
  assign pt_mag    = pt_diff[23] ? 23'(-pt_diff) : pt_diff[22:0];

  dks_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (aux_start),
    .num   ({1'b0, pt_mag, 16'd0} + 40'(pt_s)),
    .den   ({pt_s, 1'b0}),
    .busy  (div_busy),
    .quot  (quot)
  );

  dks_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (aux_start),
    .x_in  (sum_nx),
    .y_in  (sum_ny),
    .busy  (cor_busy),
    .angle (mht_phi)
  );

  // summary is loaded into the output register this cycle
  logic fin_fire;
  assign fin_fire = state == S_FINISH && !div_busy && !cor_busy && (!m_tvalid || m_tready);

  // summary fields
  logic pair_ok;
  logic triple_ok;
  logic signed [16:0] y_sum;
  logic signed [16:0] y_dif;
  logic [15:0] d_az;
  logic [15:0] dphi;
  logic signed [15:0] bal;

  always_comb begin
    pair_ok   = (jets_seen >= 2'd2);
    triple_ok = (jets_seen == 2'd3);
    y_sum = 17'(kept_rap[0]) + 17'(kept_rap[1]);
    y_dif = 17'(kept_rap[0]) - 17'(kept_rap[1]);
    d_az  = kept_az[0] - kept_az[1];
    dphi  = (d_az > 16'd32768) ? 16'(~d_az + 16'd1) : d_az;
    if (pt_s == 24'd0) begin
      bal = '0;
    end else if (pt_diff[23]) begin
      bal = 16'(~quot[16:0] + 17'd1);
    end else begin
      bal = (quot[16:0] > 17'd32767) ? 16'sh7FFF : 16'(quot[16:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      jets_seen <= '0;
      sum_nx    <= '0;
      sum_ny    <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !fin_fire) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (s_tuser) begin
              if (jets_seen != 2'd3) begin
                kept_x[jets_seen] <= in_x;
                kept_y[jets_seen] <= in_y;
                kept_z[jets_seen] <= s_tdata[3*MB-1:2*MB];
                kept_e[jets_seen] <= s_tdata[4*MB-1:3*MB];
                if (!jets_seen[1]) begin
                  kept_rap[jets_seen[0]] <= s_tdata[4*MB+15:4*MB];
                  kept_az[jets_seen[0]]  <= s_tdata[4*MB+31:4*MB+16];
                  kept_pt[jets_seen[0]]  <= s_tdata[4*MB+54:4*MB+32];
                end
                jets_seen <= jets_seen + 2'd1;
              end
              sum_nx <= (nx_next > 33'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                        (nx_next < -33'sh0_8000_0000) ? 32'sh8000_0000 : 32'(nx_next);
              sum_ny <= (ny_next > 33'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                        (ny_next < -33'sh0_8000_0000) ? 32'sh8000_0000 : 32'(ny_next);
            end
            if (s_tlast) begin
              state <= S_START;
            end
          end
        end
        S_START: begin
          job   <= JOB_PAIR;
          term  <= TERM_E;
          acc   <= '0;
          state <= S_SEL;
        end
        S_SEL: begin
          comp_mag <= comp_abs[31:0];
          state    <= S_MUL;
        end
        S_MUL: begin
          prod  <= comp_mag * comp_mag;
          state <= S_ACC;
        end
        S_ACC: begin
          acc <= neg_term ? acc - $signed({2'b00, prod}) : acc + $signed({2'b00, prod});
          if (last_term) begin
            state <= S_ROOT;
          end else begin
            term  <= term_t'(term + 2'd1);
            state <= S_SEL;
          end
        end
        S_ROOT: begin
          state <= S_RWAIT;
        end
        S_RWAIT: begin
          if (!sq_busy) begin
            unique case (job)
              JOB_PAIR: r_pair_mass <= mass_val;
              JOB_23:   r_mass_23   <= mass_val;
              JOB_3J:   r_mass_3j   <= mass_val;
              JOB_PT:   r_pair_pt   <= (sq_root > 32'd33554431) ? 25'h1FFFFFF : 25'(sq_root);
              default:  r_mht       <= sq_root;
            endcase
            acc <= '0;
            if (job == JOB_MHT) begin
              state <= S_FINISH;
            end else begin
              job   <= job_t'(job + 3'd1);
              term  <= (job == JOB_PAIR || job == JOB_23) ? TERM_E : TERM_X;
              state <= S_SEL;
            end
          end
        end
        S_FINISH: begin
          if (fin_fire) begin
            m_tvalid <= 1'b1;
            m_tuser  <= {triple_ok, pair_ok};
            m_tdata  <= {1'b0,
                         mht_phi,
                         r_mht,
                         triple_ok ? r_mass_3j : 26'sd0,
                         triple_ok ? r_mass_23 : 26'sd0,
                         pair_ok ? bal : 16'sd0,
                         pair_ok ? dphi : 16'd0,
                         pair_ok ? y_dif[16:1] : 16'd0,
                         pair_ok ? y_sum[16:1] : 16'd0,
                         pair_ok ? r_pair_pt : 25'd0,
                         pair_ok ? r_pair_mass : 26'sd0};
            jets_seen <= '0;
            sum_nx    <= '0;
            sum_ny    <= '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `DKS_ASSERT(a_sqrt_idle_start, !sq_start || !sq_busy, "root started while busy")
  `DKS_ASSERT(a_triple_has_pair, !m_tvalid || !m_tuser[1] || m_tuser[0], "triple without pair")
  `DKS_ASSERT(a_dphi_range, !m_tvalid || m_tdata[98:83] <= 16'd32768, "delta phi out of range")
  `DKS_ASSERT_NEXT(a_finish_clears, fin_fire, jets_seen == 2'd0 && m_tvalid, "event not cleared")
endmodule

### rtl/dks_sqrt.sv
module dks_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        busy,
  output logic [31:0] root
);
  logic [63:0] n;
  logic [33:0] rem;
  logic [4:0]  cnt;
  logic [35:0] rem_t;
  logic [35:0] trial;

  assign rem_t = {rem, n[63:62]};
  assign trial = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == 5'd31) begin
      busy <= 1'b0;
    end
    if (start) begin
      n    <= radicand;
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end else if (busy) begin
      n   <= {n[61:0], 2'b00};
      cnt <= cnt + 5'd1;
      if (rem_t >= trial) begin
        rem  <= 34'(rem_t - trial);
        root <= {root[30:0], 1'b1};
      end else begin
        rem  <= rem_t[33:0];
        root <= {root[30:0], 1'b0};
      end
    end
  end
endmodule

### rtl/dks_div.sv
module dks_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [39:0] num,
  input  logic [24:0] den,
  output logic        busy,
  output logic [39:0] quot
);
  logic [24:0] rem;
  logic [24:0] d;
  logic [5:0]  cnt;
  logic [25:0] rem_t;

  assign rem_t = {rem, quot[39]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == 6'd39) begin
      busy <= 1'b0;
    end
    if (start) begin
      quot <= num;
      d    <= den;
      rem  <= '0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 6'd1;
      if (rem_t >= {1'b0, d}) begin
        rem  <= 25'(rem_t - {1'b0, d});
        quot <= {quot[38:0], 1'b1};
      end else begin
        rem  <= rem_t[24:0];
        quot <= {quot[38:0], 1'b0};
      end
    end
  end
endmodule

### rtl/dks_cordic.sv
module dks_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] x_in,
  input  logic signed [31:0] y_in,
  output logic               busy,
  output logic [15:0]        angle
);
  logic signed [35:0] x;
  logic signed [35:0] y;
  logic signed [35:0] dx;
  logic signed [35:0] dy;
  logic [23:0] acc;
  logic [23:0] acc_rnd;
  logic [dks_pkg::STEP_W-1:0] idx;
  logic null_vec;

  assign dx      = y >>> idx;
  assign dy      = x >>> idx;
  assign acc_rnd = acc + 24'd128;
  assign angle   = null_vec ? 16'd0 : acc_rnd[23:8];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= !(x_in == 32'sd0 && y_in == 32'sd0);
    end else if (busy && idx == dks_pkg::STEP_W'(dks_pkg::CORDIC_STEPS - 1)) begin
      busy <= 1'b0;
    end
    if (start) begin
      null_vec <= (x_in == 32'sd0 && y_in == 32'sd0);
      idx      <= '0;
      if (x_in < 32'sd0) begin
        x   <= -36'(x_in);
        y   <= -36'(y_in);
        acc <= dks_pkg::HALF_TURN;
      end else begin
        x   <= 36'(x_in);
        y   <= 36'(y_in);
        acc <= '0;
      end
    end else if (busy) begin
      idx <= idx + 1'b1;
      if (!y[35]) begin
        x   <= x + dx;
        y   <= y - dy;
        acc <= acc + dks_pkg::atan_turn(idx);
      end else begin
        x   <= x - dx;
        y   <= y + dy;
        acc <= acc - dks_pkg::atan_turn(idx);
      end
    end
  end
endmodule

### test/dks_checker.sv
module dks_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [151:0] s_tdata,
  input  logic         s_tuser,
  input  logic         s_tlast,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [215:0] m_tdata,
  input  logic [1:0]   m_tuser,
  output int           fail_count,
  output int           pending
);
  typedef struct {
    logic        pair_valid;
    logic        triple_valid;
    logic [25:0] pair_mass;
    logic [24:0] pair_pt;
    logic [15:0] y_boost;
    logic [15:0] y_star;
    logic [15:0] delta_phi;
    logic [15:0] pt_balance;
    logic [25:0] mass_23;
    logic [25:0] mass_3j;
    logic [31:0] missing_ht;
    logic [15:0] missing_ht_phi;
  } summary_t;

  localparam longint COMP_MAX = 64'sd1073741823;
  localparam longint MASS_HI = 64'sd33554431;
  localparam longint MASS_LO = -64'sd33554432;
  localparam longint I32_HI = 64'sd2147483647;
  localparam longint I32_LO = -64'sd2147483648;

  logic [23:0] turn_step [20] = '{
    24'd2097152, 24'd1238021, 24'd654136, 24'd332049, 24'd166669, 24'd83416,
    24'd41718, 24'd20860, 24'd10430, 24'd5215, 24'd2608, 24'd1304, 24'd652,
    24'd326, 24'd163, 24'd81, 24'd41, 24'd20, 24'd10, 24'd5};

  summary_t summary_q[$];
  longint jx[3], jy[3], jz[3], je[3], jrap[2], jpt[2];
  longint jaz[2];
  int jet_count;
  longint neg_x, neg_y;

  assign pending = summary_q.size();

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint jet_sum_mass(int sel);
    longint x, y, z, e, m2, m;
    x = 0; y = 0; z = 0; e = 0;
    for (int k = 0; k < 3; k++) begin
      if (sel[k]) begin
        x += jx[k]; y += jy[k]; z += jz[k]; e += je[k];
      end
    end
    x = sat(x, -COMP_MAX, COMP_MAX);
    y = sat(y, -COMP_MAX, COMP_MAX);
    z = sat(z, -COMP_MAX, COMP_MAX);
    e = sat(e, -COMP_MAX, COMP_MAX);
    m2 = e * e - x * x - y * y - z * z;
    if (m2 >= 0) m = longint'(int_root(m2));
    else m = -longint'(int_root(-m2));
    return sat(m, MASS_LO, MASS_HI);
  endfunction

  function automatic logic [15:0] ht_angle(longint x, longint y);
    logic [23:0] acc;
    longint dx, dy;
    acc = 0;
    if (x == 0 && y == 0) return 16'd0;
    if (x < 0) begin
      x = -x; y = -y; acc = 24'd8388608;
    end
    for (int i = 0; i < 20; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; acc = acc + turn_step[i];
      end else begin
        x -= dx; y += dy; acc = acc - turn_step[i];
      end
    end
    return 16'((25'(acc) + 25'd128) >> 8);
  endfunction

  task automatic take_jet(logic present, logic lst, logic [151:0] d);
    longint px, py, p1, p2, s, df, mag, q, x, y;
    logic [15:0] dphi;
    summary_t r;
    px = longint'($signed(d[23:0]));
    py = longint'($signed(d[47:24]));
    if (present) begin
      if (jet_count < 3) begin
        jx[jet_count] = px;
        jy[jet_count] = py;
        jz[jet_count] = longint'($signed(d[71:48]));
        je[jet_count] = longint'(d[95:72]);
        if (jet_count < 2) begin
          jrap[jet_count] = longint'($signed(d[111:96]));
          jaz[jet_count] = longint'(d[127:112]);
          jpt[jet_count] = longint'(d[150:128]);
        end
        jet_count++;
      end
      neg_x = sat(neg_x - px, I32_LO, I32_HI);
      neg_y = sat(neg_y - py, I32_LO, I32_HI);
    end
    if (!lst) return;
    r = '{default: '0};
    if (jet_count >= 2) begin
      x = sat(jx[0] + jx[1], -COMP_MAX, COMP_MAX);
      y = sat(jy[0] + jy[1], -COMP_MAX, COMP_MAX);
      p1 = jpt[0]; p2 = jpt[1]; s = p1 + p2;
      dphi = 16'(jaz[0] - jaz[1]);
      r.pair_valid = 1'b1;
      r.pair_mass = 26'(jet_sum_mass(3));
      r.pair_pt = 25'(sat(longint'(int_root(x * x + y * y)), 0, 33554431));
      r.y_boost = 16'((jrap[0] + jrap[1]) >>> 1);
      r.y_star = 16'((jrap[0] - jrap[1]) >>> 1);
      r.delta_phi = dphi > 16'd32768 ? 16'(17'd65536 - dphi) : dphi;
      if (s > 0) begin
        df = p1 - p2;
        mag = df < 0 ? -df : df;
        q = ((mag <<< 16) + s) / (2 * s);
        q = df < 0 ? -q : q;
        r.pt_balance = 16'(sat(q, -32768, 32767));
      end
    end
    if (jet_count >= 3) begin
      r.triple_valid = 1'b1;
      r.mass_23 = 26'(jet_sum_mass(6));
      r.mass_3j = 26'(jet_sum_mass(7));
    end
    r.missing_ht = 32'(int_root(longint'(neg_x * neg_x) + longint'(neg_y * neg_y)));
    r.missing_ht_phi = ht_angle(neg_x, neg_y);
    summary_q.push_back(r);
    jet_count = 0;
    neg_x = 0;
    neg_y = 0;
  endtask

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", field, got, want, $time);
    fail_count++;
  endtask

  task automatic compare_summary();
    summary_t w;
    if (summary_q.size() == 0) begin
      report("unexpected transaction", 0, 0);
      return;
    end
    w = summary_q.pop_front();
    if (m_tuser[0] !== w.pair_valid) report("pair_valid", m_tuser[0], w.pair_valid);
    if (m_tuser[1] !== w.triple_valid) report("triple_valid", m_tuser[1], w.triple_valid);
    if (m_tdata[25:0] !== w.pair_mass) report("pair_mass", m_tdata[25:0], w.pair_mass);
    if (m_tdata[50:26] !== w.pair_pt) report("pair_pt", m_tdata[50:26], w.pair_pt);
    if (m_tdata[66:51] !== w.y_boost) report("y_boost", m_tdata[66:51], w.y_boost);
    if (m_tdata[82:67] !== w.y_star) report("y_star", m_tdata[82:67], w.y_star);
    if (m_tdata[98:83] !== w.delta_phi) report("delta_phi", m_tdata[98:83], w.delta_phi);
    if (m_tdata[114:99] !== w.pt_balance) report("pt_balance", m_tdata[114:99], w.pt_balance);
    if (m_tdata[140:115] !== w.mass_23) report("mass_23", m_tdata[140:115], w.mass_23);
    if (m_tdata[166:141] !== w.mass_3j) report("mass_3j", m_tdata[166:141], w.mass_3j);
    if (m_tdata[198:167] !== w.missing_ht)
      report("missing_ht", m_tdata[198:167], w.missing_ht);
    if (m_tdata[214:199] !== w.missing_ht_phi)
      report("missing_ht_phi", m_tdata[214:199], w.missing_ht_phi);
  endtask

  initial begin
    fail_count = 0;
    jet_count = 0;
    neg_x = 0;
    neg_y = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) compare_summary();
      if (s_tvalid && s_tready) take_jet(s_tuser, s_tlast, s_tdata);
    end
  end

  final begin
    if (summary_q.size() != 0) $display("%0d summaries never arrived", summary_q.size());
  end
endmodule

### test/tb_dijet_kinematics_summary_unit.sv
module tb_dijet_kinematics_summary_unit;
  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [151:0] s_tdata = '0;
  logic         s_tuser = 0;
  logic         s_tlast = 0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [215:0] m_tdata;
  logic [1:0]   m_tuser;
  int           fail_count;
  int           pending;
  int           tx_idle = 25;
  int           rx_idle = 78;
  int           jets_sent = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  dijet_kinematics_summary_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  dks_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .fail_count(fail_count), .pending(pending)
  );

  always @(negedge clk) begin
    if (!rst) m_tready <= ($urandom_range(99) >= rx_idle);
  end

  function automatic logic [151:0] jet_word(logic [23:0] px, logic [23:0] py,
      logic [23:0] pz, logic [23:0] e, logic [15:0] rap, logic [15:0] az,
      logic [22:0] pt);
    return {1'b0, pt, az, rap, e, pz, py, px};
  endfunction

  function automatic logic [23:0] rand_comp();
    case ($urandom_range(7))
      0: return 24'h7fffff;
      1: return 24'h800000;
      2: return 24'h0;
      3, 4: return 24'($urandom());
      default: return 24'($signed($urandom_range(4000000)) - 2000000);
    endcase
  endfunction

  function automatic logic [151:0] rand_jet();
    logic [23:0] px, py, pz, e;
    px = rand_comp();
    py = rand_comp();
    pz = rand_comp();
    case ($urandom_range(3))
      0: e = 24'($urandom());
      1: e = $urandom_range(1) ? 24'hffffff : 24'h0;
      default: e = 24'($urandom_range(8388607) + 6000000);
    endcase
    return jet_word(px, py, pz, e, 16'($urandom()), 16'($urandom()),
      $urandom_range(3) == 0 ? 23'($urandom()) : 23'($urandom_range(500000)));
  endfunction

  // one transaction, with random hold-off of tvalid beforehand
  task automatic send(logic present, logic lst, logic [151:0] d);
    while ($urandom_range(99) < tx_idle) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= present;
    s_tlast <= lst;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    jets_sent++;
  endtask

  initial begin
    int nj;
    bit tail_empty;
    bit heavy;
    logic [151:0] w;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // empty event, lone jet, noise item
    send(0, 1, '0);
    send(0, 0, '1);
    send(1, 1, rand_jet());
    // extreme pair, second pt zero so balance saturates
    send(1, 0, jet_word(24'h7fffff, 24'h7fffff, 24'h7fffff, 24'hffffff,
      16'h7fff, 16'h0000, 23'h7fffff));
    send(1, 1, jet_word(24'h800000, 24'h800000, 24'h800000, 24'hffffff,
      16'h8000, 16'hffff, 23'h0));
    // zero pt sum, half-turn phi gap, spacelike mass
    send(1, 0, jet_word(24'h7fffff, 24'h0, 24'h0, 24'h0, 16'h8000, 16'h8000, 23'h0));
    send(1, 1, jet_word(24'h100, 24'h7fffff, 24'h800000, 24'h0, 16'h8000, 16'h0, 23'h0));
    // equal pt, opposite x and y momenta so missing ht is null
    send(1, 0, jet_word(24'd5000, 24'd3000, 24'd10, 24'd90000, 16'd12, 16'd100, 23'd77));
    send(1, 1, jet_word(-24'sd5000, -24'sd3000, 24'd10, 24'd90000, 16'd13, 16'd65000,
      23'd77));
    // five jets, tlast on an empty item
    for (int k = 0; k < 5; k++) send(1, 0, rand_jet());
    send(0, 0, rand_jet());
    send(0, 1, rand_jet());
    // three heavy jets so the three-jet mass saturates
    for (int k = 0; k < 3; k++)
      send(1, k == 2, jet_word(24'd0, 24'd0, 24'd0, 24'hffffff, 16'h0, 16'h0, 23'h1));

    while (jets_sent < 1900) begin
      if (jets_sent >= 1267) begin
        tx_idle = 0; rx_idle = 0;
      end else if (jets_sent >= 633) begin
        tx_idle = 78; rx_idle = 25;
      end
      heavy = ($urandom_range(60) == 0);
      nj = heavy ? $urandom_range(300, 260) : $urandom_range(5);
      tail_empty = (nj == 0) || ($urandom_range(4) == 0);
      for (int k = 0; k < nj; k++) begin
        if ($urandom_range(9) == 0) send(0, 0, rand_jet());
        if (heavy) begin
          w = rand_jet();
          w[23:0] = $urandom_range(1) ? 24'h800000 : 24'h7fffff;
          w[47:24] = $urandom_range(1) ? 24'h800000 : 24'h7fffff;
          if ($urandom_range(1)) w[47:24] = w[23:0];
        end else begin
          w = rand_jet();
        end
        send(1, !tail_empty && k == nj - 1, w);
      end
      if (tail_empty) send(0, 1, rand_jet());
    end
    s_tvalid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(12 * 3000000);
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
